// File: sv/ddo_pkg.sv
// Package: types, widths and CORDIC angle table for the odometry update core.
`default_nettype none
package ddo_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = 4;
    localparam int IDX_W        = 2;
    localparam int CFG_W        = 24;

    localparam logic [IDX_W-1:0] REG_DIST_PER_TICK = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEADING_GAIN  = 2'd1;

    localparam logic [15:0] DIST_PER_TICK_RST = 16'd6146;
    localparam logic [23:0] HEADING_GAIN_RST  = 24'd658970;
    localparam logic signed [19:0] CORDIC_X0  = 20'sd39797;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TURN, ST_DIST, ST_ROT, ST_MXL, ST_MXH, ST_MYL, ST_MYH, ST_WRITE
    } state_t;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic signed [33:0] cordic_atan(input logic [ITER_W-1:0] i);
        case (i)
            4'd0:    cordic_atan = 34'sd536870912;
            4'd1:    cordic_atan = 34'sd316933406;
            4'd2:    cordic_atan = 34'sd167458907;
            4'd3:    cordic_atan = 34'sd85004756;
            4'd4:    cordic_atan = 34'sd42667331;
            4'd5:    cordic_atan = 34'sd21354465;
            4'd6:    cordic_atan = 34'sd10679838;
            4'd7:    cordic_atan = 34'sd5340245;
            4'd8:    cordic_atan = 34'sd2670163;
            4'd9:    cordic_atan = 34'sd1335087;
            4'd10:   cordic_atan = 34'sd667544;
            4'd11:   cordic_atan = 34'sd333772;
            4'd12:   cordic_atan = 34'sd166886;
            4'd13:   cordic_atan = 34'sd83443;
            4'd14:   cordic_atan = 34'sd41722;
            default: cordic_atan = 34'sd20861;
        endcase
    endfunction
endpackage
`default_nettype wire

// File: sv/diff_drive_odometry_update_core.sv
// Differential-drive odometry update: shared multiplier plus sequenced CORDIC.
// Each sample runs the accept state, 16 CORDIC iterations, 6 passes through the single
// 25x18 multiplier and the result write; the write waits while m_tready holds off
// the previous result, and no new sample is taken until the write is done.
// Reset (aresetn low, synchronous): pose cleared to zero, registers to defaults,
// no result pending.
`default_nettype none
module diff_drive_odometry_update_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [ddo_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [ddo_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [47:0]                 s_tdata,  // yaw_angle, left_ticks, right_ticks
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [79:0]                      m_tdata   // pose_x, pose_y, pose_heading
);
    import ddo_pkg::*;

    state_t state_reg, state_next;
    logic [ITER_W-1:0] iter_reg;
    logic [15:0] dpt_reg;
    logic [23:0] gain_reg;
    logic [31:0] px_reg, py_reg;
    logic [15:0] hd_reg;
    logic signed [15:0] yaw_reg;
    logic signed [16:0] sum_reg, dif_reg;
    logic signed [41:0] turn_reg;
    logic signed [33:0] dsum_reg;
    logic signed [33:0] z_reg;
    logic signed [19:0] x_reg, y_reg;
    logic flip_reg;
    logic signed [51:0] acc_reg;
    logic m_valid_reg;
    logic [79:0] m_data_reg;

    // shared multiplier
    logic signed [24:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] prod;
    logic signed [17:0] cos_v, sin_v;

    assign cos_v = flip_reg ? 18'(-x_reg) : x_reg[17:0];
    assign sin_v = flip_reg ? 18'(-y_reg) : y_reg[17:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_TURN: begin mul_a = {1'b0, gain_reg}; mul_b = 18'(dif_reg); end
            ST_DIST: begin mul_a = {9'b0, dpt_reg};  mul_b = 18'(sum_reg); end
            ST_MXL:  begin mul_a = {8'b0, dsum_reg[16:0]}; mul_b = cos_v; end
            ST_MXH:  begin mul_a = 25'($signed(dsum_reg[33:17])); mul_b = cos_v; end
            ST_MYL:  begin mul_a = {8'b0, dsum_reg[16:0]}; mul_b = sin_v; end
            ST_MYH:  begin mul_a = 25'($signed(dsum_reg[33:17])); mul_b = sin_v; end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;

    // angle terms from the turn product
    logic signed [42:0] t_half, t_chg;
    logic [15:0] half_v, ang_v;
    assign t_half = 43'(turn_reg) + 43'sd65536;
    assign t_chg  = 43'(turn_reg) + 43'sd32768;
    assign half_v = t_half[32:17];
    assign ang_v  = yaw_reg + half_v;

    // CORDIC step and final high partial product
    logic signed [19:0] xs, ys;
    logic signed [51:0] acc_sum;
    logic signed [51:0] rnd;
    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;
    assign acc_sum = acc_reg + (52'(prod) <<< 17);
    assign rnd = acc_sum + 52'sd16777216;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_TURN;
            ST_TURN:  state_next = ST_DIST;
            ST_DIST:  state_next = ST_ROT;
            ST_ROT:   if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) state_next = ST_MXL;
            ST_MXL:   state_next = ST_MXH;
            ST_MXH:   state_next = ST_MYL;
            ST_MYL:   state_next = ST_MYH;
            ST_MYH:   state_next = ST_WRITE;
            ST_WRITE: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            dpt_reg     <= DIST_PER_TICK_RST;
            gain_reg    <= HEADING_GAIN_RST;
            px_reg      <= '0;
            py_reg      <= '0;
            hd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == REG_DIST_PER_TICK) dpt_reg <= cfg_wdata[15:0];
                else if (cfg_index == REG_HEADING_GAIN) gain_reg <= cfg_wdata;
            end
            if (state_reg == ST_WRITE && (!m_valid_reg || m_tready)) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    yaw_reg <= s_tdata[15:0];
                    sum_reg <= 17'($signed(s_tdata[31:16])) + 17'($signed(s_tdata[47:32]));
                    dif_reg <= 17'($signed(s_tdata[47:32])) - 17'($signed(s_tdata[31:16]));
                end
                ST_TURN: turn_reg <= prod[41:0];
                ST_DIST: begin
                    dsum_reg <= prod[33:0];
                    hd_reg   <= yaw_reg + t_chg[31:16];
                    iter_reg <= '0;
                    x_reg    <= CORDIC_X0;
                    y_reg    <= '0;
                    // fold angles beyond a quarter turn by a half turn
                    if ($signed(ang_v) > 16'sd16384) begin
                        z_reg    <= {{2{ang_v[15]}}, ang_v, 16'b0} - 34'sd2147483648;
                        flip_reg <= 1'b1;
                    end else if ($signed(ang_v) < -16'sd16384) begin
                        z_reg    <= {{2{ang_v[15]}}, ang_v, 16'b0} + 34'sd2147483648;
                        flip_reg <= 1'b1;
                    end else begin
                        z_reg    <= {{2{ang_v[15]}}, ang_v, 16'b0};
                        flip_reg <= 1'b0;
                    end
                end
                ST_ROT: begin
                    iter_reg <= iter_reg + 1'b1;
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - cordic_atan(iter_reg);
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + cordic_atan(iter_reg);
                    end
                end
                ST_MXL, ST_MYL: acc_reg <= 52'(prod);
                ST_MXH: px_reg <= px_reg + 32'($signed(rnd[51:25]));
                ST_MYH: py_reg <= py_reg + 32'($signed(rnd[51:25]));
                ST_WRITE: if (!m_valid_reg || m_tready) begin
                    m_data_reg  <= {hd_reg, py_reg, px_reg};
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/ddo_checker.sv
// Port-level checker for the odometry update core, with its bind.
`default_nettype none
module ddo_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata
);
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");
    a_no_result_soon: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid) else $error("result too early");
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready) else $error("bad reset state");
endmodule

bind diff_drive_odometry_update_core ddo_checker u_ddo_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// File: tb/diff_drive_odometry_update_core_tb.sv
// Self-checking testbench for the odometry update core: pose prediction and random stalls.
`default_nettype none
module diff_drive_odometry_update_core_tb;
    import ddo_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [79:0]          m_tdata;

    typedef struct packed {
        logic [15:0] heading;
        logic [31:0] y;
        logic [31:0] x;
    } pose_t;

    logic [15:0] dist_per_tick;
    logic [23:0] heading_gain;
    logic [31:0] pos_x, pos_y;
    logic [15:0] hdg;
    pose_t       pose_q[$];

    int  errors = 0;
    int  cycles = 0;
    bit  rx_idle_en = 1'b1;
    bit  tx_idle_en = 1'b1;
    int  rx_hold = 0;

    diff_drive_odometry_update_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint floor_sra(longint v, int s);
        return v >>> s;
    endfunction

    // Fixed 16-step CORDIC on a 16-bit binary angle; returns Q16 cos and sin.
    task automatic cordic_rotate(input logic [15:0] ang, output longint c, output longint s);
        longint z, x, y, nx;
        bit     flip;
        z = longint'($signed(ang)) * 65536;
        x = 39797;
        y = 0;
        flip = 1'b0;
        if (z > (64'sd1 <<< 30)) begin
            z -= 64'sd1 <<< 31;
            flip = 1'b1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += 64'sd1 <<< 31;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - floor_sra(y, i);
                y = y + floor_sra(x, i);
                z -= longint'(cordic_atan(i[3:0]));
            end else begin
                nx = x + floor_sra(y, i);
                y = y - floor_sra(x, i);
                z += longint'(cordic_atan(i[3:0]));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_pose(input logic [47:0] d);
        longint yaw, lt, rt, dsum, turn, chg, half, c, s, dx, dy;
        pose_t  p;
        yaw = longint'($signed(d[15:0]));
        lt = longint'($signed(d[31:16]));
        rt = longint'($signed(d[47:32]));
        dsum = longint'(dist_per_tick) * (lt + rt);
        turn = longint'(heading_gain) * (rt - lt);
        chg = floor_sra(turn + (64'sd1 <<< 15), 16);
        half = floor_sra(turn + (64'sd1 <<< 16), 17);
        cordic_rotate(16'(yaw + half), c, s);
        dx = floor_sra(dsum * c + (64'sd1 <<< 24), 25);
        dy = floor_sra(dsum * s + (64'sd1 <<< 24), 25);
        pos_x = pos_x + 32'(dx);
        pos_y = pos_y + 32'(dy);
        hdg = 16'(yaw) + 16'(chg);
        p.x = pos_x;
        p.y = pos_y;
        p.heading = hdg;
        pose_q.push_back(p);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        errors++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycles);
    endtask

    // Receiver: random stall bursts plus an optional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_hold <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pose_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pose_q.size() == 0) begin
                report("unexpected transaction", got.x, 32'd0);
            end else begin
                exp = pose_q.pop_front();
                if (got.x !== exp.x) report("pose_x", got.x, exp.x);
                if (got.y !== exp.y) report("pose_y", got.y, exp.y);
                if (got.heading !== exp.heading)
                    report("pose_heading", {16'd0, got.heading}, {16'd0, exp.heading});
            end
        end
    end

    task automatic send_sample(input logic [15:0] yaw, input logic [15:0] lt,
                               input logic [15:0] rt);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {rt, lt, yaw};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pose({rt, lt, yaw});
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_DIST_PER_TICK) dist_per_tick = val[15:0];
        else if (idx == REG_HEADING_GAIN) heading_gain = val;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_ticks();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    task automatic test_directed;
        logic [15:0] ext[6];
        ext = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 16'hC000};
        foreach (ext[i]) send_sample(ext[i], 16'd100, 16'd100);
        send_sample(16'h0000, 16'h7FFF, 16'h7FFF);
        send_sample(16'h1234, 16'h8000, 16'h8000);
        // large turns in both directions
        send_sample(16'h2000, 16'h8000, 16'h7FFF);
        send_sample(16'hE000, 16'h7FFF, 16'h8000);
        send_sample(16'h4001, 16'h0000, 16'h0000);
        send_sample(16'hBFFF, 16'hFFFF, 16'h0001);
        send_sample(16'h5555, 16'hAAAA, 16'h5555);
        drain();
    endtask

    task automatic test_registers;
        write_reg(REG_DIST_PER_TICK, 24'hFFFFFF);    // upper bits dropped
        write_reg(REG_HEADING_GAIN, 24'hFFFFFF);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
        send_sample(16'h0100, 16'h7FFF, 16'h7FFF);
        drain();
        write_reg(2'd2, 24'h000001);                 // unknown index, ignored
        write_reg(2'd3, 24'h000002);
        send_sample(16'h0100, 16'h0300, 16'h0200);
        drain();
        write_reg(REG_DIST_PER_TICK, 24'd0);
        write_reg(REG_HEADING_GAIN, 24'd0);
        send_sample(16'h3000, 16'h7FFF, 16'h8000);
        drain();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) begin
                drain();
                write_reg(REG_DIST_PER_TICK, 24'($urandom));
                write_reg(REG_HEADING_GAIN, 24'($urandom));
            end
            send_sample(16'($urandom), rand_ticks(), rand_ticks());
        end
        drain();
    endtask

    task automatic test_backpressure;
        // load the hold-off away from the receiver's clock edge
        @(negedge aclk);
        rx_hold = 300;
        @(posedge aclk);
        for (int i = 0; i < 20; i++) send_sample(16'($urandom), rand_ticks(), rand_ticks());
        drain();
    endtask

    initial begin
        dist_per_tick = DIST_PER_TICK_RST;
        heading_gain = HEADING_GAIN_RST;
        pos_x = '0;
        pos_y = '0;
        hdg = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_registers();
        test_random(560);
        test_backpressure();
        write_reg(REG_DIST_PER_TICK, 24'd6146);
        write_reg(REG_HEADING_GAIN, 24'd658970);
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        test_random(100);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
